>>> hdl/krt_pkg.sv
// Package for the keyed record table: field widths, request and status codes,
// controller state encoding and the per-cell command word.
// Depends on nothing; every other file in hdl/ imports it.
package krt_pkg;

  // Default sizing of the table.
  localparam int unsigned DEPTH_DEF        = 64;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  // Fixed widths of the word fields.
  localparam int unsigned OP_W   = 3;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned PAY_W  = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CNT_W  = 7;

  // Request codes.
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 3'd0,
    OP_INSERT = 3'd1,
    OP_UPDATE = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4
  } req_type_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 3'd0,
    ST_PRESENT = 3'd1,
    ST_ABSENT  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } ctrl_state_e;

  // Command to one table cell.
  typedef struct packed {
    logic load_new;   // take the request key and payload
    logic shift_in;   // take the contents of the next cell up
    logic write_pay;  // replace only the payload
  } cell_cmd_t;

  // Registered copy of an accepted request word.
  typedef struct packed {
    req_type_e          req_type;
    logic [KEY_W-1:0]   entry_key;
    logic [PAY_W-1:0]   entry_payload;
    logic [POS_W-1:0]   entry_position;
  } req_t;

  // Result word held in the output register.
  typedef struct packed {
    status_e            status;
    logic [POS_W-1:0]   found_position;
    logic [KEY_W-1:0]   out_key;
    logic [PAY_W-1:0]   out_payload;
    logic [CNT_W-1:0]   entry_count;
  } rsp_t;

endpackage

>>> hdl/krt_if.sv
// Valid/ready channel interfaces for the keyed record table: one for request
// words and one for result words.
// Depends on krt_pkg for the field widths.
interface krt_req_if;
  import krt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         req_type;
  logic signed [KEY_W-1:0] entry_key;
  logic [PAY_W-1:0]        entry_payload;
  logic [POS_W-1:0]        entry_position;

  modport source (output valid, req_type, entry_key, entry_payload, entry_position,
                  input ready);
  modport sink   (input valid, req_type, entry_key, entry_payload, entry_position,
                  output ready);
endinterface

interface krt_rsp_if;
  import krt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [POS_W-1:0]        found_position;
  logic signed [KEY_W-1:0] out_key;
  logic [PAY_W-1:0]        out_payload;
  logic [CNT_W-1:0]        entry_count;

  modport source (output valid, status, found_position, out_key, out_payload, entry_count,
                  input ready);
  modport sink   (input valid, status, found_position, out_key, out_payload, entry_count,
                  output ready);
endinterface

>>> hdl/krt_cell.sv
// One entry of the record table: key and payload registers, a key comparator
// with a registered match flag, and a load path from the next cell up.
// Depends on krt_pkg.
module krt_cell #(
  parameter int unsigned PAYLOAD_BITS = krt_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                       clk_i,
  input  krt_pkg::cell_cmd_t         cmd_i,
  input  logic                       cmp_en_i,
  input  logic [krt_pkg::KEY_W-1:0]  cmp_key_i,
  input  logic [krt_pkg::KEY_W-1:0]  new_key_i,
  input  logic [PAYLOAD_BITS-1:0]    new_pay_i,
  input  logic [krt_pkg::KEY_W-1:0]  next_key_i,
  input  logic [PAYLOAD_BITS-1:0]    next_pay_i,
  output logic [krt_pkg::KEY_W-1:0]  key_o,
  output logic [PAYLOAD_BITS-1:0]    pay_o,
  output logic                       match_o
);
  import krt_pkg::*;

  logic [KEY_W-1:0]        key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic                    match_q;

  // Compare against the key of the word being accepted.
  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      match_q <= (key_q == cmp_key_i);
    end
  end

  // Entry storage: new record, shift down from the neighbor, or payload rewrite.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_new) begin
      key_q <= new_key_i;
      pay_q <= new_pay_i;
    end else if (cmd_i.shift_in) begin
      key_q <= next_key_i;
      pay_q <= next_pay_i;
    end else if (cmd_i.write_pay) begin
      pay_q <= new_pay_i;
    end
  end

  assign key_o   = key_q;
  assign pay_o   = pay_q;
  assign match_o = match_q;

endmodule

>>> hdl/keyed_record_table_top.sv
// Top level of the keyed record table: request register, controller, the row
// of table cells and the result register.
// Depends on krt_pkg, krt_if.sv and krt_cell.
//
//   channel  dir  modport  contents
//   req_i    in   sink     req_type, entry_key, entry_payload, entry_position
//   rsp_o    out  source   status, found_position, out_key, out_payload, entry_count
//
// For each request, on the accept edge every cell compares its key with the
// request key; in the execute state the controller resolves the match
// vector, updates the cells (insert, payload rewrite, or a one-place shift down
// for delete) and loads the result register. A stalled result register holds
// the execute state until it frees up. Reset clears the state, the live count and
// the result valid flag; the cell contents are not reset.
module keyed_record_table_top #(
  parameter int unsigned DEPTH        = krt_pkg::DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = krt_pkg::PAYLOAD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  krt_req_if.sink    req_i,
  krt_rsp_if.source  rsp_o
);
  import krt_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LC_W  = $clog2(DEPTH + 1);
  localparam int unsigned XW    = (LC_W > POS_W) ? LC_W : POS_W;

  ctrl_state_e           state_q, state_d;
  req_t                  req_q;
  logic [LC_W-1:0]       count_q, count_d;
  logic                  out_valid_q;
  rsp_t                  out_q, res;

  logic                  accept, exec_fire;
  logic [KEY_W-1:0]      cell_key [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];
  logic [DEPTH-1:0]      match, hit_vec, pos_sel, ins_sel, shift_sel, rd_sel;
  cell_cmd_t             cmd [DEPTH];

  logic [PAYLOAD_BITS-1:0] new_pay;
  logic [63:0]           pay_in64, pay_out64;
  logic                  any_hit, pos_ok, is_full;
  logic [IDX_W-1:0]      hit_idx;
  logic [XW-1:0]         pos_x, cnt_x;
  logic [KEY_W-1:0]      sel_key;
  logic [PAYLOAD_BITS-1:0] sel_pay;
  logic                  do_ins, do_upd, do_del;

  // Handshake.
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign exec_fire   = (state_q == S_EXEC) && (!out_valid_q || rsp_o.ready);

  // Controller.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.req_type       <= req_type_e'(req_i.req_type);
      req_q.entry_key      <= req_i.entry_key;
      req_q.entry_payload  <= req_i.entry_payload;
      req_q.entry_position <= req_i.entry_position;
    end
    if (exec_fire) begin
      out_q <= res;
    end
  end

  // Payload resized to the stored width.
  assign pay_in64 = {32'b0, req_q.entry_payload};
  assign new_pay  = pay_in64[PAYLOAD_BITS-1:0];

  // Row of cells; each one shifts in from the cell above it on delete.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0]        nxt_key;
    logic [PAYLOAD_BITS-1:0] nxt_pay;
    if (g == DEPTH - 1) begin : g_last
      assign nxt_key = cell_key[g];
      assign nxt_pay = cell_pay[g];
    end else begin : g_mid
      assign nxt_key = cell_key[g+1];
      assign nxt_pay = cell_pay[g+1];
    end
    krt_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd[g]),
      .cmp_en_i   (accept),
      .cmp_key_i  (req_i.entry_key),
      .new_key_i  (req_q.entry_key),
      .new_pay_i  (new_pay),
      .next_key_i (nxt_key),
      .next_pay_i (nxt_pay),
      .key_o      (cell_key[g]),
      .pay_o      (cell_pay[g]),
      .match_o    (match[g])
    );
  end

  // Per-cell decodes: live hit, position select, append slot and shift range.
  assign pos_x = XW'(req_q.entry_position);
  assign cnt_x = XW'(count_q);
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit_vec[i]   = match[i] && (LC_W'(i) < count_q);
      pos_sel[i]   = (pos_x == XW'(i));
      ins_sel[i]   = (count_q == LC_W'(i));
      shift_sel[i] = (pos_x <= XW'(i));
    end
  end

  assign any_hit = |hit_vec;
  assign pos_ok  = (pos_x < cnt_x);
  assign is_full = (count_q == LC_W'(DEPTH));
  assign rd_sel  = (req_q.req_type == OP_LOOKUP) ? hit_vec : pos_sel;

  // Index of the matching cell and contents of the selected cell.
  always_comb begin
    hit_idx = '0;
    sel_key = '0;
    sel_pay = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_idx = hit_idx | (hit_vec[i] ? IDX_W'(i) : '0);
      sel_key = sel_key | (rd_sel[i] ? cell_key[i] : '0);
      sel_pay = sel_pay | (rd_sel[i] ? cell_pay[i] : '0);
    end
  end

  assign pay_out64 = 64'(sel_pay);

  // Request execution and result word.
  always_comb begin
    count_d            = count_q;
    do_ins             = 1'b0;
    do_upd             = 1'b0;
    do_del             = 1'b0;
    res.status         = ST_DONE;
    res.found_position = '0;
    res.out_key        = '0;
    res.out_payload    = '0;
    case (req_q.req_type)
      OP_LOOKUP: begin
        if (any_hit) begin
          res.found_position = POS_W'(hit_idx);
          res.out_key        = sel_key;
          res.out_payload    = pay_out64[PAY_W-1:0];
        end else begin
          res.status = ST_ABSENT;
        end
      end
      OP_INSERT: begin
        if (any_hit) begin
          res.status         = ST_PRESENT;
          res.found_position = POS_W'(hit_idx);
        end else if (is_full) begin
          res.status = ST_FULL;
        end else begin
          do_ins             = 1'b1;
          res.found_position = POS_W'(count_q);
          count_d            = count_q + LC_W'(1);
        end
      end
      OP_UPDATE: begin
        if (any_hit) begin
          do_upd             = 1'b1;
          res.found_position = POS_W'(hit_idx);
        end else begin
          res.status = ST_ABSENT;
        end
      end
      OP_DELETE: begin
        if (pos_ok) begin
          do_del             = 1'b1;
          res.found_position = req_q.entry_position;
          count_d            = count_q - LC_W'(1);
        end else begin
          res.status = ST_RANGE;
        end
      end
      OP_READ: begin
        if (pos_ok) begin
          res.found_position = req_q.entry_position;
          res.out_key        = sel_key;
          res.out_payload    = pay_out64[PAY_W-1:0];
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    res.entry_count = CNT_W'(count_d);
    if (!exec_fire) begin
      count_d = count_q;
    end
  end

  // Cell commands, only in the cycle the result is committed.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cmd[i].load_new  = exec_fire && do_ins && ins_sel[i];
      cmd[i].shift_in  = exec_fire && do_del && shift_sel[i];
      cmd[i].write_pay = exec_fire && do_upd && hit_vec[i];
    end
  end

  // Result channel.
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.found_position = out_q.found_position;
  assign rsp_o.out_key        = out_q.out_key;
  assign rsp_o.out_payload    = out_q.out_payload;
  assign rsp_o.entry_count    = out_q.entry_count;

endmodule
